@@ rtl/ccu_pkg.sv @@
// Package for the CRC codeword checker / unpacker: payload structs, config
// constants and the shared check and repack functions.
// No dependencies; imported by every module of the block.
`default_nettype none

package ccu_pkg;

    // Widest generator and derived widths
    localparam int MAX_GEN_BITS = 16;
    localparam int MAX_DATA_BITS = 8;
    localparam int CW_W = MAX_GEN_BITS + MAX_DATA_BITS - 1;
    localparam int LEN_W = $clog2(CW_W + 1);
    localparam int GLEN_W = 5;
    localparam int DLEN_W = 4;
    localparam int CNT_W = 32;

    // Config register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_POLY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GLEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DLEN = 2'd2;

    // Config register reset values
    localparam logic [MAX_GEN_BITS-1:0] POLY_RST = 16'd11;
    localparam logic [GLEN_W-1:0] GLEN_RST = 5'd4;
    localparam logic [DLEN_W-1:0] DLEN_RST = 4'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_header;
    } t_in_item;

    typedef struct packed {
        logic             byte_ready;
        logic [7:0]       out_byte;
        logic [CNT_W-1:0] codeword_total;
        logic [CNT_W-1:0] codeword_errors;
    } t_out_item;

    // Clamped, ready-to-use configuration
    typedef struct packed {
        logic [MAX_GEN_BITS-1:0] poly;
        logic [GLEN_W-1:0]       glen;
        logic [DLEN_W-1:0]       dlen;
        logic [LEN_W-1:0]        cwlen;
    } t_cfg;

    // One byte's worth of work handed from front to back
    typedef struct packed {
        logic            is_header;
        logic            cw0_vld;
        logic [CW_W-1:0] cw0;
        logic            cw1_vld;
        logic [CW_W-1:0] cw1;
    } t_cw_entry;

    typedef struct packed {
        logic [7:0] pbuf;
        logic [2:0] cnt;
        logic       emit;
        logic [7:0] byte_val;
    } t_pack;

    function automatic logic [GLEN_W-1:0] glen_clamp(input logic [GLEN_W-1:0] v);
        logic [GLEN_W-1:0] r;
        r = v;
        if (v < GLEN_W'(2)) r = GLEN_W'(2);
        if (v > GLEN_W'(MAX_GEN_BITS)) r = GLEN_W'(MAX_GEN_BITS);
        return r;
    endfunction

    function automatic logic [DLEN_W-1:0] dlen_clamp(input logic [DLEN_W-1:0] v);
        logic [DLEN_W-1:0] r;
        r = v;
        if (v < DLEN_W'(4)) r = DLEN_W'(4);
        if (v > DLEN_W'(MAX_DATA_BITS)) r = DLEN_W'(MAX_DATA_BITS);
        return r;
    endfunction

    // Mask of the low len bits; len equal to CW_W wraps to all ones
    function automatic logic [CW_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        return (CW_W'(1) << len) - CW_W'(1);
    endfunction

    // Mod-2 long division; true when the remainder is nonzero
    function automatic logic crc_nonzero(input logic [CW_W-1:0] cw,
                                         input t_cfg cfg);
        logic [CW_W-1:0] r;
        logic [CW_W-1:0] gen;
        logic [LEN_W-1:0] top;
        r = cw;
        gen = CW_W'(cfg.poly) & ((CW_W'(1) << cfg.glen) - CW_W'(1));
        for (int i = MAX_DATA_BITS; i >= 1; i--) begin
            top = LEN_W'(i) + LEN_W'(cfg.glen) - LEN_W'(2);
            if (DLEN_W'(i) <= cfg.dlen && r[top]) begin
                r = r ^ (gen << (i - 1));
            end
        end
        return |r;
    endfunction

    // Dataword is the upper dlen bits of the codeword
    function automatic logic [7:0] cw_data(input logic [CW_W-1:0] cw, input t_cfg cfg);
        logic [CW_W-1:0] s;
        logic [8:0] m;
        s = cw >> (cfg.glen - GLEN_W'(1));
        m = (9'd1 << cfg.dlen) - 9'd1;
        return s[7:0] & m[7:0];
    endfunction

    // Append dlen data bits to the pack buffer, emit a byte when 8 are held
    function automatic t_pack pack_step(input logic [7:0] pbuf, input logic [2:0] cnt,
                                        input logic [7:0] data, input logic [DLEN_W-1:0] d);
        t_pack p;
        logic [15:0] comb;
        logic [3:0] tot;
        logic [15:0] keep;
        comb = ({8'd0, pbuf} << d) | {8'd0, data};
        tot = {1'b0, cnt} + d;
        p = '0;
        if (tot >= 4'd8) begin
            p.emit = 1'b1;
            p.byte_val = 8'(comb >> (tot - 4'd8));
            p.cnt = 3'(tot - 4'd8);
            keep = comb & ((16'd1 << p.cnt) - 16'd1);
            p.pbuf = keep[7:0];
        end else begin
            p.cnt = tot[2:0];
            p.pbuf = comb[7:0];
        end
        return p;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v, input logic en);
        return (en && v != '1) ? v + CNT_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ccu_front.sv @@
// Front part: accepts stream bytes, skips pad bits, assembles codewords and
// queues up to two finished codewords per byte for the back part.
// Depends on ccu_pkg.
`default_nettype none

module ccu_front
    import ccu_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire t_in_item  i_item,
    input  wire t_cfg      i_cfg,
    input  wire logic      i_mq_pop,
    output logic           o_mq_empty,
    output t_cw_entry      o_mq_head
);

    logic [CW_W-1:0]  r_shift, n_shift;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic [2:0]       r_pad, n_pad;
    t_cw_entry        n_ent;
    logic [CW_W-1:0]  lmask;

    t_cw_entry  r_mq [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       accept;

    assign full = (r_cnt == 2'd2);
    assign o_mq_empty = (r_cnt == 2'd0);
    assign o_mq_head = r_mq[r_rp];
    assign accept = push && !full;
    assign lmask = len_mask(i_cfg.cwlen);

    // Bit walk over one byte, MSB first
    always_comb begin
        n_shift = r_shift;
        n_idx = r_idx;
        n_pad = r_pad;
        n_ent = '0;
        n_ent.is_header = i_item.is_header;
        if (i_item.is_header) begin
            n_shift = '0;
            n_idx = '0;
            n_pad = i_item.in_byte[2:0];
        end else begin
            for (int b = 7; b >= 0; b--) begin
                if (n_pad != 3'd0) begin
                    n_pad = n_pad - 3'd1;
                end else begin
                    n_shift = ((n_shift << 1) | CW_W'(i_item.in_byte[3'(b)])) & lmask;
                    n_idx = n_idx + LEN_W'(1);
                    if (n_idx >= i_cfg.cwlen) begin
                        if (!n_ent.cw0_vld) begin
                            n_ent.cw0_vld = 1'b1;
                            n_ent.cw0 = n_shift;
                        end else begin
                            n_ent.cw1_vld = 1'b1;
                            n_ent.cw1 = n_shift;
                        end
                        n_idx = '0;
                        n_shift = '0;
                    end
                end
            end
        end
    end

    // Assembly state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_idx <= '0;
            r_pad <= '0;
        end else if (accept) begin
            r_shift <= n_shift;
            r_idx <= n_idx;
            r_pad <= n_pad;
        end
    end

    // Two-entry queue toward the back part
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mq[r_wp] <= n_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (accept) r_wp <= ~r_wp;
            if (i_mq_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(accept) - 2'(i_mq_pop);
        end
    end

endmodule

`default_nettype wire

@@ rtl/ccu_back.sv @@
// Back part: checks queued codewords, keeps the saturating counters, repacks
// datawords into bytes and queues one result per input byte.
// Depends on ccu_pkg.
`default_nettype none

module ccu_back
    import ccu_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cfg      i_cfg,
    input  wire logic      i_mq_empty,
    input  wire t_cw_entry i_mq_head,
    output logic           o_mq_pop,
    output logic           empty,
    input  wire logic      pop,
    output t_out_item      o_item
);

    logic [7:0]       r_pbuf;
    logic [2:0]       r_pcnt;
    logic [CNT_W-1:0] r_tot, r_err;
    t_pack            pk0, pk1, pk;
    logic [CNT_W-1:0] n_tot, n_err;
    t_out_item        n_res;

    t_out_item  r_oq [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       take, deq;

    assign take = !i_mq_empty && (r_cnt != 2'd2);
    assign o_mq_pop = take;
    assign empty = (r_cnt == 2'd0);
    assign deq = pop && !empty;
    assign o_item = r_oq[r_rp];

    // Check, count and repack one entry
    always_comb begin
        pk0 = pack_step(r_pbuf, r_pcnt, cw_data(i_mq_head.cw0, i_cfg), i_cfg.dlen);
        if (!i_mq_head.cw0_vld) begin
            pk0 = '0;
            pk0.pbuf = r_pbuf;
            pk0.cnt = r_pcnt;
        end
        pk1 = pack_step(pk0.pbuf, pk0.cnt, cw_data(i_mq_head.cw1, i_cfg), i_cfg.dlen);
        pk = pk1;
        if (!i_mq_head.cw1_vld) begin
            pk = pk0;
        end else if (!pk1.emit) begin
            pk.emit = pk0.emit;
            pk.byte_val = pk0.byte_val;
        end
        n_tot = sat_inc(sat_inc(r_tot, i_mq_head.cw0_vld), i_mq_head.cw1_vld);
        n_err = sat_inc(sat_inc(r_err,
                    i_mq_head.cw0_vld && crc_nonzero(i_mq_head.cw0, i_cfg)),
                    i_mq_head.cw1_vld && crc_nonzero(i_mq_head.cw1, i_cfg));
        if (i_mq_head.is_header) begin
            pk = '0;
            n_tot = '0;
            n_err = '0;
        end
        n_res.byte_ready = pk.emit;
        n_res.out_byte = pk.emit ? pk.byte_val : 8'd0;
        n_res.codeword_total = n_tot;
        n_res.codeword_errors = n_err;
    end

    // Running pack and counter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pbuf <= '0;
            r_pcnt <= '0;
            r_tot <= '0;
            r_err <= '0;
        end else if (take) begin
            r_pbuf <= pk.pbuf;
            r_pcnt <= pk.cnt;
            r_tot <= n_tot;
            r_err <= n_err;
        end
    end

    // Two-entry result queue
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_oq[r_wp] <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (take) r_wp <= ~r_wp;
            if (deq) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(take) - 2'(deq);
        end
    end

endmodule

`default_nettype wire

@@ rtl/crc_codeword_checker_unpacker.sv @@
// CRC codeword checker and dataword unpacker, top level.
// Holds the config registers; instantiates ccu_front and ccu_back (ccu_pkg).
//
// Usage:
//   Input channel: present a byte on i_in with push; it is taken on a clock
//   edge where push is high and full is low. is_header marks the stream's
//   first byte; its low three bits give the pad bits to skip, and it clears
//   the codeword assembly, the pack buffer and both counters.
//   Result channel: while empty is low, o_out carries the oldest result;
//   it is taken on an edge where pop is high. Every input byte gives exactly
//   one result: byte_ready/out_byte for a completed output byte, and the
//   running codeword_total and codeword_errors.
//   Config: write i_cfg_data to register i_cfg_idx with i_cfg_we, only while
//   the block holds no unfinished item.
// Timing: one byte per cycle sustained while the queues are not full. A byte
//   is registered in the front queue, then in the result queue, where it is
//   visible. The front bit walk and the back check/repack each finish one byte per cycle.
// Reset: synchronous, active low; clears queues and running state and loads
//   the config defaults (generator 0xB, length 4, dataword 4).
// Stall: two-entry queues sit between front and back and at the output; when
//   pop stays low they fill and full rises within four accepted bytes.
`default_nettype none

module crc_codeword_checker_unpacker
    import ccu_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire t_in_item               i_in,
    output logic                        empty,
    input  wire logic                   pop,
    output t_out_item                   o_out,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [MAX_GEN_BITS-1:0] i_cfg_data
);

    logic [MAX_GEN_BITS-1:0] r_poly;
    logic [GLEN_W-1:0]       r_glen;
    logic [DLEN_W-1:0]       r_dlen;
    t_cfg                    cfg;
    logic                    mq_pop, mq_empty;
    t_cw_entry               mq_head;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= POLY_RST;
            r_glen <= GLEN_RST;
            r_dlen <= DLEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_POLY: r_poly <= i_cfg_data;
                CFG_IDX_GLEN: r_glen <= i_cfg_data[GLEN_W-1:0];
                CFG_IDX_DLEN: r_dlen <= i_cfg_data[DLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamped view of the config
    always_comb begin
        cfg.poly = r_poly;
        cfg.glen = glen_clamp(r_glen);
        cfg.dlen = dlen_clamp(r_dlen);
        cfg.cwlen = LEN_W'(cfg.dlen) + LEN_W'(cfg.glen) - LEN_W'(1);
    end

    ccu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_in),
        .i_cfg      (cfg),
        .i_mq_pop   (mq_pop),
        .o_mq_empty (mq_empty),
        .o_mq_head  (mq_head)
    );

    ccu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_mq_empty (mq_empty),
        .i_mq_head  (mq_head),
        .o_mq_pop   (mq_pop),
        .empty      (empty),
        .pop        (pop),
        .o_item     (o_out)
    );

endmodule

`default_nettype wire

@@ rtl/ccu_checker.sv @@
// Port-level checks for crc_codeword_checker_unpacker, bound to the top level.
// Depends on ccu_pkg.
`default_nettype none

module ccu_checker
    import ccu_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      full,
    input wire logic      empty,
    input wire logic      pop,
    input wire t_out_item o_out
);

    // Reset leaves both queues drained
    a_reset_drains: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not drained after reset");

    // A waiting result holds until it is taken
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out))
        else $error("waiting result changed");

    // Errored codewords are a subset of checked ones
    a_err_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_out.codeword_errors <= o_out.codeword_total)
        else $error("error count above total count");

    // No byte means a zero byte field
    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_out.byte_ready |-> o_out.out_byte == 8'd0)
        else $error("out_byte nonzero without byte_ready");

endmodule

bind crc_codeword_checker_unpacker ccu_checker u_ccu_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_out   (o_out)
);

`default_nettype wire
